// File: src/satellite_arc_tracker_macros.svh
// assertion helpers for the arc tracker checker
`ifndef SATELLITE_ARC_TRACKER_MACROS_SVH
`define SATELLITE_ARC_TRACKER_MACROS_SVH

// same-cycle implication, disabled while in reset
`define SAT_TRK_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sat_trk check failed");

// next-cycle implication, disabled while in reset
`define SAT_TRK_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sat_trk check failed");

`endif

// File: src/sat_trk_pkg.sv
package sat_trk_pkg;

    localparam int SAT_W      = 6;
    localparam int EPOCH_W    = 48;
    localparam int ARC_W      = 16;
    localparam int PERIOD_W   = 32;
    localparam int ENTRY_W    = ARC_W + EPOCH_W;

    localparam int SAT_LSB     = 0;
    localparam int EPOCH_LSB   = SAT_LSB + SAT_W;
    localparam int PRESENT_BIT = EPOCH_LSB + EPOCH_W;
    localparam int SLIP_BIT    = PRESENT_BIT + 1;
    localparam int IN_TDATA_W  = 56;

    localparam int REJECT_BIT  = ARC_W;
    localparam int OUT_TDATA_W = 24;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = PERIOD_W;

    localparam int NUM_SATS_DEF = 64;

    localparam logic [ARC_W-1:0] ARC_MAX = '1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_UNSTABLE_PERIOD,
        CFG_DELETE_UNSTABLE
    } cfg_reg_t;

endpackage

// File: src/sat_trk_ram.sv
module sat_trk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic                                       re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/satellite_arc_tracker.sv
// channel  | dir | tdata fields (lsb first)                        | tuser | tlast
// s_axis   | in  | sat_index 6, epoch_ms 48, flag_present, slip_flag | -     | -
// m_axis   | out | arc_number 16, reject, 7 zero bits                | -     | -
// cfg      | in  | cfg_we, cfg_index, cfg_data (32 bits)             | -     | -
//
// one item per cycle unless the output stalls; an item passes through the stage one registers, then the output register
// the table entry is read at the input transfer and written back on an arc change as the item moves on;
// a back-to-back item for the same satellite takes the written value by bypass
// reset clears the arc counts through one valid bit per satellite, no clearing pass
// a stalled output holds the result and the stage behind it; input stalls only when both are full
module satellite_arc_tracker #(
    parameter int NUM_SATS = sat_trk_pkg::NUM_SATS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // sat_index, epoch_ms, flag_present, slip_flag
    input  logic [sat_trk_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // arc_number, reject, zero pad
    output logic [sat_trk_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input  logic                                   cfg_we,
    input  logic [sat_trk_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [sat_trk_pkg::CFG_DATA_W-1:0]     cfg_data
);

    import sat_trk_pkg::*;

    localparam int AW = (NUM_SATS > 1) ? $clog2(NUM_SATS) : 1;

    // configuration
    logic [PERIOD_W-1:0] period_reg;
    logic                del_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= '0;
            del_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_UNSTABLE_PERIOD: period_reg <= cfg_data[PERIOD_W-1:0];
                CFG_DELETE_UNSTABLE: del_reg    <= cfg_data[0];
            endcase
        end
    end

    // handshake
    logic s1_valid_reg;
    logic out_valid_reg;
    logic out_free;
    logic s1_fire;
    logic in_acc;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s1_fire       = s1_valid_reg && out_free;
    assign s_axis_tready = !s1_valid_reg || out_free;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    // input fields
    logic [SAT_W-1:0]   in_sat;
    logic [EPOCH_W-1:0] in_epoch;
    logic [AW-1:0]      in_addr;

    assign in_sat   = s_axis_tdata[SAT_LSB +: SAT_W];
    assign in_epoch = s_axis_tdata[EPOCH_LSB +: EPOCH_W];
    assign in_addr  = AW'(in_sat);

    // stage one registers
    logic [SAT_W-1:0]   s1_sat_reg;
    logic [EPOCH_W-1:0] s1_epoch_reg;
    logic               s1_present_reg;
    logic               s1_slip_reg;
    logic               rd_valid_reg;
    logic               fwd_hit_reg;
    logic [ARC_W-1:0]   fwd_arc_reg;
    logic [EPOCH_W-1:0] fwd_last_reg;
    logic [NUM_SATS-1:0] arc_valid_reg;

    // write-back signals
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [ARC_W-1:0]   wr_arc;
    logic [ENTRY_W-1:0] ram_rdata;
    logic               fwd_hit_next;

    assign wr_addr      = AW'(s1_sat_reg);
    assign fwd_hit_next = wr_en && (wr_addr == in_addr);

    sat_trk_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_SATS)
    ) u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata ({s1_epoch_reg, wr_arc}),
        .re    (in_acc),
        .raddr (in_addr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_hit_reg   <= 1'b0;
            arc_valid_reg <= '0;
        end
        else
        begin
            if (in_acc)
            begin
                s1_valid_reg <= 1'b1;
                fwd_hit_reg  <= fwd_hit_next;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (wr_en)
            begin
                arc_valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_sat_reg     <= in_sat;
            s1_epoch_reg   <= in_epoch;
            s1_present_reg <= s_axis_tdata[PRESENT_BIT];
            s1_slip_reg    <= s_axis_tdata[SLIP_BIT];
            rd_valid_reg   <= arc_valid_reg[in_addr];
            fwd_arc_reg    <= wr_arc;
            fwd_last_reg   <= s1_epoch_reg;
        end
    end

    // arc decision
    logic               in_range;
    logic [ARC_W-1:0]   arc_cur;
    logic [EPOCH_W-1:0] last_cur;
    logic [EPOCH_W:0]   diff_ab;
    logic [EPOCH_W:0]   diff_ba;
    logic [EPOCH_W-1:0] epoch_gap;
    logic               unstable;
    logic [ARC_W-1:0]   arc_inc;
    logic               update;
    logic [ARC_W-1:0]   res_arc;
    logic               res_reject;

    always_comb
    begin
        in_range = 32'(s1_sat_reg) < NUM_SATS;
        if (fwd_hit_reg)
        begin
            arc_cur  = fwd_arc_reg;
            last_cur = fwd_last_reg;
        end
        else
        begin
            arc_cur  = rd_valid_reg ? ram_rdata[ARC_W-1:0] : '0;
            last_cur = ram_rdata[ARC_W +: EPOCH_W];
        end
        diff_ab   = {1'b0, s1_epoch_reg} - {1'b0, last_cur};
        diff_ba   = {1'b0, last_cur} - {1'b0, s1_epoch_reg};
        epoch_gap = diff_ab[EPOCH_W] ? diff_ba[EPOCH_W-1:0] : diff_ab[EPOCH_W-1:0];
        unstable  = (arc_cur != '0) && (epoch_gap <= EPOCH_W'(period_reg));
        arc_inc   = (arc_cur == ARC_MAX) ? arc_cur : arc_cur + ARC_W'(1);

        update     = 1'b0;
        res_arc    = arc_cur;
        res_reject = 1'b0;
        if (!in_range)
        begin
            res_arc    = '0;
            res_reject = 1'b1;
        end
        else if (!s1_present_reg)
        begin
            res_reject = 1'b1;
        end
        else if (unstable)
        begin
            res_reject = del_reg && (arc_cur > ARC_W'(1));
        end
        else if (s1_slip_reg)
        begin
            update     = 1'b1;
            res_arc    = arc_inc;
            res_reject = del_reg && (arc_inc > ARC_W'(1));
        end
    end

    assign wr_en  = s1_fire && update;
    assign wr_arc = arc_inc;

    // output register
    logic [ARC_W-1:0] out_arc_reg;
    logic             out_reject_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            out_arc_reg    <= res_arc;
            out_reject_reg <= res_reject;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(OUT_TDATA_W - ARC_W - 1)'(0), out_reject_reg, out_arc_reg};

endmodule

// File: src/sat_trk_checker.sv
`include "satellite_arc_tracker_macros.svh"

module sat_trk_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                s_axis_tvalid,
    input logic                                s_axis_tready,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [sat_trk_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    logic       in_acc;
    logic       out_acc;
    logic [1:0] pending_reg;

    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign out_acc  = m_axis_tvalid && m_axis_tready;

    // items inside the block: one in the decision stage, one in the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else if (in_acc && !out_acc)
        begin
            pending_reg <= pending_reg + 2'd1;
        end
        else if (out_acc && !in_acc)
        begin
            pending_reg <= pending_reg - 2'd1;
        end
    end

    `SAT_TRK_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata))
    `SAT_TRK_ASSERT_NOW(a_no_phantom, clk, rst_n, m_axis_tvalid, pending_reg != 2'd0)
    `SAT_TRK_ASSERT_NOW(a_capacity, clk, rst_n, in_acc && (pending_reg == 2'd2),
        out_acc)
    `SAT_TRK_ASSERT_NEXT(a_result_follows, clk, rst_n,
        in_acc && (pending_reg == 2'd0), ##1 m_axis_tvalid)

endmodule

bind satellite_arc_tracker sat_trk_checker u_sat_trk_checker (.*);

// File: tb/satellite_arc_tracker_tb.sv
`timescale 1ns / 1ps

module satellite_arc_tracker_tb;

    import sat_trk_pkg::*;

    localparam int NSAT = NUM_SATS_DEF;

    typedef struct packed {
        bit [SAT_W-1:0]   sat;
        bit [EPOCH_W-1:0] epoch;
        bit               present;
        bit               slip;
    } observation_t;

    typedef struct packed {
        bit [ARC_W-1:0] arc_number;
        bit             reject;
    } arc_result_t;

    class arc_scoreboard;
        bit [ARC_W-1:0]    arc_tbl[NSAT];
        bit [EPOCH_W-1:0]  change_tbl[NSAT];
        bit [PERIOD_W-1:0] period;
        bit                drop_unstable;
        arc_result_t       arc_results_q[$];
        int                errors;
        int                checked;
        int                rejects;
        int                new_arcs;
        int                top_arc;

        function void clear_state();
            foreach (arc_tbl[i])
            begin
                arc_tbl[i]    = '0;
                change_tbl[i] = '0;
            end
            period        = '0;
            drop_unstable = 1'b0;
        endfunction

        function void write_reg(cfg_reg_t idx, bit [CFG_DATA_W-1:0] val);
            if (idx == CFG_UNSTABLE_PERIOD)
                period = val[PERIOD_W-1:0];
            else
                drop_unstable = val[0];
        endfunction

        function void note_observation(observation_t obs);
            bit [ARC_W-1:0]   arc;
            bit [EPOCH_W-1:0] epoch_gap;
            arc_result_t      res;
            arc        = arc_tbl[obs.sat];
            res.reject = 1'b0;
            if (!obs.present)
                res.reject = 1'b1;
            else
            begin
                epoch_gap = (obs.epoch >= change_tbl[obs.sat])
                            ? obs.epoch - change_tbl[obs.sat]
                            : change_tbl[obs.sat] - obs.epoch;
                if (arc != '0 && epoch_gap <= {16'd0, period})
                begin
                    if (drop_unstable && arc > 1)
                        res.reject = 1'b1;
                end
                else if (obs.slip)
                begin
                    if (arc != '1)
                        arc++;
                    arc_tbl[obs.sat]    = arc;
                    change_tbl[obs.sat] = obs.epoch;
                    new_arcs++;
                    if (drop_unstable && arc > 1)
                        res.reject = 1'b1;
                end
            end
            if (arc > top_arc)
                top_arc = int'(arc);
            res.arc_number = arc;
            arc_results_q.push_back(res);
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] data);
            arc_result_t want;
            if (arc_results_q.size() == 0)
            begin
                $error("result transfer with no observation pending: tdata %h", data);
                errors++;
                return;
            end
            want = arc_results_q.pop_front();
            checked++;
            if (want.reject)
                rejects++;
            if (data[ARC_W-1:0] !== want.arc_number)
            begin
                $error("arc_number: expected %0d, actual %0d", want.arc_number,
                       data[ARC_W-1:0]);
                errors++;
            end
            if (data[REJECT_BIT] !== want.reject)
            begin
                $error("reject: expected %0d, actual %0d", want.reject, data[REJECT_BIT]);
                errors++;
            end
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    // sat_index, epoch_ms, flag_present, slip_flag
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // arc_number, reject, zero pad
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    arc_scoreboard sb = new();
    bit            send_idle = 1'b1;
    bit            recv_idle = 1'b1;
    bit            hold_req  = 1'b0;
    int            n_sent;
    int            n_phases;

    satellite_arc_tracker u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    task automatic send_obs(input observation_t o);
        int gap;
        gap = send_idle ? $urandom_range(0, 13) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {o.slip, o.present, o.epoch, o.sat};
        do @(posedge clk); while (!s_axis_tready);
        sb.note_observation(o);
        n_sent++;
        @(negedge clk);
    endtask

    task automatic send_fields(input int sat, input bit [EPOCH_W-1:0] epoch,
                               input bit present, input bit slip);
        observation_t o;
        o.sat     = SAT_W'(sat);
        o.epoch   = epoch;
        o.present = present;
        o.slip    = slip;
        send_obs(o);
    endtask

    // called right after the last transfer of a burst, same falling edge
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.arc_results_q.size() != 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input bit [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        sb.write_reg(idx, val);
    endtask

    task automatic set_phase(input bit [PERIOD_W-1:0] period, input bit drop);
        drain();
        write_reg(CFG_UNSTABLE_PERIOD, period);
        write_reg(CFG_DELETE_UNSTABLE, drop);
        n_phases++;
    endtask

    function automatic observation_t random_obs();
        observation_t     o;
        bit [EPOCH_W-1:0] d;
        o.sat     = $urandom_range(0, 1) ? SAT_W'($urandom_range(0, 3))
                                         : SAT_W'($urandom_range(0, NSAT - 1));
        o.present = ($urandom_range(0, 9) != 0);
        o.slip    = ($urandom_range(0, 9) < 6);
        case ($urandom_range(0, 9))
            0: o.epoch = {16'($urandom), $urandom};
            1: o.epoch = $urandom_range(0, 1) ? '0 : '1;
            default:
            begin
                // land around the edge of the unstable window
                case ($urandom_range(0, 5))
                    0: d = {16'd0, sb.period};
                    1: d = {16'd0, sb.period} + 1;
                    2: d = EPOCH_W'($urandom_range(0, sb.period));
                    3: d = {16'd0, sb.period} - 1;
                    4: d = '0;
                    default: d = {14'd0, 2'($urandom_range(0, 3)), $urandom};
                endcase
                o.epoch = $urandom_range(0, 1) ? sb.change_tbl[o.sat] + d
                                               : sb.change_tbl[o.sat] - d;
            end
        endcase
        return o;
    endfunction

    initial
    begin
        m_axis_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            int gap;
            gap = recv_idle ? $urandom_range(0, 13) : 0;
            if (hold_req)
            begin
                hold_req = 1'b0;
                gap      = 300;
            end
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
            sb.check_result(m_axis_tdata);
            @(negedge clk);
        end
    end

    initial
    begin
        bit [EPOCH_W-1:0] ep;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_UNSTABLE_PERIOD;
        cfg_data      = '0;
        rst_n         = 1'b0;
        sb.clear_state();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset config: zero period, no deletion
        send_fields(0, 48'd50, 1'b1, 1'b0);
        send_fields(0, 48'd60, 1'b0, 1'b1);
        send_fields(0, 48'd100, 1'b1, 1'b1);
        send_fields(0, 48'd100, 1'b1, 1'b1);
        send_fields(0, 48'd101, 1'b1, 1'b1);
        send_fields(0, 48'd101, 1'b0, 1'b0);
        send_fields(63, '1, 1'b1, 1'b1);
        send_fields(63, '0, 1'b1, 1'b1);

        // widest window, deletion on
        set_phase('1, 1'b1);
        send_fields(63, '0, 1'b1, 1'b1);
        send_fields(63, 48'hFFFF_FFFF, 1'b1, 1'b1);
        send_fields(63, 48'h1_0000_0000, 1'b1, 1'b1);
        send_fields(63, '0, 1'b1, 1'b1);
        send_fields(5, 48'd1000, 1'b1, 1'b1);
        send_fields(5, 48'd1001, 1'b1, 1'b1);
        send_fields(5, 48'd999, 1'b1, 1'b0);
        send_fields(5, 48'd999, 1'b0, 1'b1);
        send_fields(63, '1, 1'b1, 1'b0);
        send_fields(42, 48'h8000_0000_0000, 1'b1, 1'b0);

        for (int ph = 0; ph < 7; ph++)
        begin
            case (ph)
                0: set_phase('0, 1'b0);
                1: set_phase('0, 1'b1);
                2: set_phase('1, 1'b1);
                3: set_phase($urandom_range(1, 40), 1'b1);
                4: set_phase($urandom, 1'b0);
                5: set_phase($urandom_range(100, 5000), 1'($urandom_range(0, 1)));
                default: set_phase($urandom_range(1, 40), 1'b0);
            endcase
            send_idle = (ph != 5);
            recv_idle = (ph != 5);
            repeat (170) send_obs(random_obs());
            send_idle = 1'b1;
            recv_idle = 1'b1;
        end

        // long output stall while input keeps coming
        set_phase($urandom_range(1, 40), 1'b1);
        hold_req  = 1'b1;
        send_idle = 1'b0;
        repeat (40) send_obs(random_obs());
        send_idle = 1'b1;

        // arc changes on one satellite, back to back
        set_phase('0, 1'b1);
        send_idle = 1'b0;
        recv_idle = 1'b0;
        ep = sb.change_tbl[42];
        for (int i = 0; i < 20; i++)
        begin
            ep++;
            send_fields(42, ep, 1'b1, 1'b1);
        end
        send_fields(42, ep, 1'b1, 1'b1);
        send_fields(42, ep + 5, 1'b1, 1'b1);
        send_fields(42, ep + 5, 1'b1, 1'b0);
        send_fields(42, ep, 1'b0, 1'b1);
        send_idle = 1'b1;
        recv_idle = 1'b1;

        drain();
        repeat (10) @(posedge clk);
        $display("run covered %0d observations over %0d config phases, %0d results checked",
                 n_sent, n_phases, sb.checked);
        $display("%0d rejects, %0d arc changes, highest arc count %0d",
                 sb.rejects, sb.new_arcs, sb.top_arc);
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
